// ===== hdl/bez_pkg.sv =====
// ---------------------------------------------------------------------------
// bez_pkg
// Shared types, constants and the per-point operation schedule of the cubic
// Bezier point generator.
// ---------------------------------------------------------------------------
package bez_pkg;

  // segment count register
  localparam int unsigned SEG_W     = 7;
  localparam logic [SEG_W-1:0] SEG_RESET = 7'd16;

  // operand memory: eight control points, then twelve interpolation results
  localparam int unsigned MEM_DEPTH = 20;
  localparam int unsigned ADDR_W    = 5;

  localparam logic [ADDR_W-1:0] A_P0X = 5'd0;
  localparam logic [ADDR_W-1:0] A_P0Y = 5'd1;
  localparam logic [ADDR_W-1:0] A_P1X = 5'd2;
  localparam logic [ADDR_W-1:0] A_P1Y = 5'd3;
  localparam logic [ADDR_W-1:0] A_P2X = 5'd4;
  localparam logic [ADDR_W-1:0] A_P2Y = 5'd5;
  localparam logic [ADDR_W-1:0] A_P3X = 5'd6;
  localparam logic [ADDR_W-1:0] A_P3Y = 5'd7;
  localparam logic [ADDR_W-1:0] A_L2X = 5'd8;
  localparam logic [ADDR_W-1:0] A_L2Y = 5'd9;
  localparam logic [ADDR_W-1:0] A_HX  = 5'd10;
  localparam logic [ADDR_W-1:0] A_HY  = 5'd11;
  localparam logic [ADDR_W-1:0] A_R3X = 5'd12;
  localparam logic [ADDR_W-1:0] A_R3Y = 5'd13;
  localparam logic [ADDR_W-1:0] A_L3X = 5'd14;
  localparam logic [ADDR_W-1:0] A_L3Y = 5'd15;
  localparam logic [ADDR_W-1:0] A_R2X = 5'd16;
  localparam logic [ADDR_W-1:0] A_R2Y = 5'd17;
  localparam logic [ADDR_W-1:0] A_FX  = 5'd18;
  localparam logic [ADDR_W-1:0] A_FY  = 5'd19;

  // control point copy counter
  localparam int unsigned LD_W = 4;
  localparam logic [LD_W-1:0] LD_DONE = 4'd8;

  // sequencer step within one point
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_LAST = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] src_a;
    logic [ADDR_W-1:0] src_b;
    logic [ADDR_W-1:0] dst;
    logic              fin_x;
    logic              fin_y;
  } op_t;

  function automatic op_t mk_op(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b,
                                input logic [ADDR_W-1:0] d);
    op_t op;
    op.valid = 1'b1;
    op.src_a = a;
    op.src_b = b;
    op.dst   = d;
    op.fin_x = (d == A_FX);
    op.fin_y = (d == A_FY);
    return op;
  endfunction

  // x and y interleave so each result is back in memory before it is read
  function automatic op_t sched(input logic [STEP_W-1:0] step);
    op_t op;
    unique case (step)
      5'd0:    op = mk_op(A_P0X, A_P1X, A_L2X);
      5'd1:    op = mk_op(A_P0Y, A_P1Y, A_L2Y);
      5'd2:    op = mk_op(A_P1X, A_P2X, A_HX);
      5'd3:    op = mk_op(A_P1Y, A_P2Y, A_HY);
      5'd4:    op = mk_op(A_P2X, A_P3X, A_R3X);
      5'd5:    op = mk_op(A_P2Y, A_P3Y, A_R3Y);
      5'd6:    op = mk_op(A_L2X, A_HX,  A_L3X);
      5'd7:    op = mk_op(A_L2Y, A_HY,  A_L3Y);
      5'd8:    op = mk_op(A_HX,  A_R3X, A_R2X);
      5'd9:    op = mk_op(A_HY,  A_R3Y, A_R2Y);
      5'd12:   op = mk_op(A_L3X, A_R2X, A_FX);
      5'd13:   op = mk_op(A_L3Y, A_R2Y, A_FY);
      default: op = '0;
    endcase
    return op;
  endfunction

endpackage

// ===== hdl/bez_div.sv =====
// ---------------------------------------------------------------------------
// bez_div
// Bit-serial restoring divider giving floor(2^FRAC_BITS / n) and its
// remainder, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bez_div
  import bez_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [SEG_W-1:0]     divisor,
  output logic                 done,
  output logic [FRAC_BITS-1:0] quot,
  output logic [SEG_W-1:0]     remd
);

  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);

  logic [CNT_W-1:0]   cnt;
  logic               running;
  logic [FRAC_BITS:0] q;
  logic [SEG_W:0]     shifted;
  logic               fits;

  // dividend is a single one in its top bit
  assign shifted = {remd, (cnt == '0)};
  assign fits    = (shifted >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(FRAC_BITS)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      remd <= '0;
      q    <= '0;
    end else if (running) begin
      remd <= fits ? SEG_W'(shifted - {1'b0, divisor}) : shifted[SEG_W-1:0];
      q    <= {q[FRAC_BITS-1:0], fits};
    end
  end

  // n is at least two, so the top quotient bit is always clear
  assign quot = q[FRAC_BITS-1:0];

endmodule

// ===== hdl/bez_lerp.sv =====
// ---------------------------------------------------------------------------
// bez_lerp
// Operand memory and the shared interpolation pipeline a + ((b - a) * t >>> F):
// memory read, subtract, multiply, add and write back.
// ---------------------------------------------------------------------------
module bez_lerp
  import bez_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ld_en,
  input  logic [ADDR_W-1:0]      ld_addr,
  input  logic [COORD_WIDTH-1:0] ld_data,
  input  op_t                    op,
  input  logic [FRAC_BITS-1:0]   t,
  output op_t                    res_op,
  output logic [COORD_WIDTH-1:0] res
);

  logic [COORD_WIDTH-1:0] mem [MEM_DEPTH];

  op_t                           op1, op2;
  logic [COORD_WIDTH-1:0]        rd_a, rd_b;
  logic [COORD_WIDTH-1:0]        a2, a3;
  logic signed [COORD_WIDTH:0]   diff, diff2;
  logic signed [FRAC_BITS:0]     t_s;
  logic signed [COORD_WIDTH+FRAC_BITS+1:0] prod;
  logic [COORD_WIDTH-1:0]        part3;

  always_ff @(posedge clk) begin
    if (ld_en) begin
      mem[ld_addr] <= ld_data;
    end else if (res_op.valid) begin
      mem[res_op.dst] <= res;
    end
    rd_a <= mem[op.src_a];
    rd_b <= mem[op.src_b];
  end

  assign diff = signed'({rd_b[COORD_WIDTH-1], rd_b}) - signed'({rd_a[COORD_WIDTH-1], rd_a});
  assign t_s  = signed'({1'b0, t});
  assign prod = diff2 * t_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      op1    <= '0;
      op2    <= '0;
      res_op <= '0;
    end else begin
      op1    <= op;
      op2    <= op1;
      res_op <= op2;
    end
  end

  always_ff @(posedge clk) begin
    diff2 <= diff;
    a2    <= rd_a;
    // floor shift, then wrap to the coordinate width
    part3 <= prod[FRAC_BITS +: COORD_WIDTH];
    a3    <= a2;
  end

  assign res = a3 + part3;

endmodule

// ===== hdl/cubic_bezier_point_generator.sv =====
// ---------------------------------------------------------------------------
// cubic_bezier_point_generator
// Emits N-1 points of a cubic Bezier curve at t = floor(k * 2^F / N) using
// de Casteljau interpolation on one shared subtract-multiply-add pipeline.
// ---------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------
//  config    | cfg_we                    | cfg_data (segment count)
//  curve in  | start, busy               | p0_x .. p3_y
//  point out | point_valid (one cycle)   | pt_x, pt_y, step_index, last_point
//
//  a curve is taken when start is high and busy low; busy then stays high
//  through the serial divider for 2^F / N and then the sequencer steps of each
//  point, twelve interpolations per point through the shared pipeline
//  the last point of a curve shows in the first cycle with busy low
//  segment counts below two take the curve with no points and busy stays low
//  reset is synchronous and clears the sequencer; the receiver cannot stall
// ---------------------------------------------------------------------------
module cubic_bezier_point_generator
  import bez_pkg::*;
#(
  parameter int unsigned COORD_WIDTH  = 32,
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [SEG_W-1:0]                  cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic [COORD_WIDTH-1:0]            p0_x,
  input  logic [COORD_WIDTH-1:0]            p0_y,
  input  logic [COORD_WIDTH-1:0]            p1_x,
  input  logic [COORD_WIDTH-1:0]            p1_y,
  input  logic [COORD_WIDTH-1:0]            p2_x,
  input  logic [COORD_WIDTH-1:0]            p2_y,
  input  logic [COORD_WIDTH-1:0]            p3_x,
  input  logic [COORD_WIDTH-1:0]            p3_y,
  output logic                              point_valid,
  output logic [COORD_WIDTH-1:0]            pt_x,
  output logic [COORD_WIDTH-1:0]            pt_y,
  output logic [$clog2(MAX_SEGMENTS)-1:0]   step_index,
  output logic                              last_point
);

  localparam int unsigned K_W = $clog2(MAX_SEGMENTS);

  state_t state, state_next;

  logic [SEG_W-1:0]       segment_count;
  logic [SEG_W-1:0]       n_eff, n_reg;
  logic                   accept, div_go, div_done;
  logic [FRAC_BITS-1:0]   div_q;
  logic [SEG_W-1:0]       div_r;
  logic [COORD_WIDTH-1:0] hold [8];
  logic [LD_W-1:0]        ld_cnt;
  logic                   ld_en;
  logic [K_W-1:0]         k, last_k;
  logic [STEP_W-1:0]      step;
  logic [FRAC_BITS-1:0]   t;
  logic [SEG_W-1:0]       rem, rem_next;
  logic [SEG_W:0]         rr;
  logic                   carry;
  op_t                    op, res_op;
  logic [COORD_WIDTH-1:0] res, px_hold;

  assign n_eff  = (segment_count > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : segment_count;
  assign accept = start && !busy;
  assign last_k = K_W'(n_reg - SEG_W'(1));
  assign ld_en  = (ld_cnt != LD_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= SEG_RESET;
    end else if (cfg_we) begin
      segment_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    busy       = 1'b1;
    op         = '0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start && (n_eff >= SEG_W'(2))) begin
          div_go     = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        op = sched(step);
        if ((step == STEP_LAST) && (k == last_k)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control points go from the holding registers into operand memory
  always_ff @(posedge clk) begin
    if (accept) begin
      hold[0] <= p0_x;
      hold[1] <= p0_y;
      hold[2] <= p1_x;
      hold[3] <= p1_y;
      hold[4] <= p2_x;
      hold[5] <= p2_y;
      hold[6] <= p3_x;
      hold[7] <= p3_y;
      n_reg   <= n_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_cnt <= LD_DONE;
    end else if (div_go) begin
      ld_cnt <= '0;
    end else if (ld_en) begin
      ld_cnt <= ld_cnt + LD_W'(1);
    end
  end

  // k * 2^F = t * n + rem is kept exact by adding the quotient and remainder
  assign rr       = {1'b0, rem} + {1'b0, div_r};
  assign carry    = (rr >= {1'b0, n_reg});
  assign rem_next = carry ? SEG_W'(rr - {1'b0, n_reg}) : rr[SEG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      k    <= '0;
      step <= '0;
      t    <= '0;
      rem  <= '0;
    end else if ((state == ST_DIV) && div_done) begin
      k    <= K_W'(1);
      step <= '0;
      t    <= div_q;
      rem  <= div_r;
    end else if (state == ST_RUN) begin
      if (step == STEP_LAST) begin
        step <= '0;
        k    <= k + K_W'(1);
        t    <= t + div_q + {{(FRAC_BITS-1){1'b0}}, carry};
        rem  <= rem_next;
      end else begin
        step <= step + STEP_W'(1);
      end
    end
  end

  bez_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .divisor (n_eff),
    .done    (div_done),
    .quot    (div_q),
    .remd    (div_r)
  );

  bez_lerp #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_lerp (
    .clk     (clk),
    .rst     (rst),
    .ld_en   (ld_en),
    .ld_addr (ADDR_W'(ld_cnt[2:0])),
    .ld_data (hold[ld_cnt[2:0]]),
    .op      (op),
    .t       (t),
    .res_op  (res_op),
    .res     (res)
  );

  // x finishes before y; the transaction goes out with y
  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else begin
      point_valid <= res_op.valid && res_op.fin_y;
    end
  end

  always_ff @(posedge clk) begin
    if (res_op.valid && res_op.fin_x) begin
      px_hold <= res;
    end
    if (res_op.valid && res_op.fin_y) begin
      pt_x       <= px_hold;
      pt_y       <= res;
      step_index <= k;
      last_point <= (k == last_k);
    end
  end

`ifndef SYNTH
  a_point_from_run: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> ($past(state) == ST_RUN))
    else $error("point strobe without a running sequence");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (point_valid && last_point) |-> (state == ST_IDLE))
    else $error("last point seen while the sequencer keeps running");

  a_load_before_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (ld_cnt == LD_DONE))
    else $error("interpolation started before control points were loaded");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !div_go)
    else $error("divider restarted during setup");
`endif

endmodule

// ===== test/cubic_bezier_point_generator_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cubic_bezier_point_generator_tb
// Drives control point sets into the Bezier point generator under a range of
// segment counts and checks every emitted point against a fixed-point
// de Casteljau predictor kept in a small scoreboard.
// ---------------------------------------------------------------------------
module cubic_bezier_point_generator_tb;
  import bez_pkg::*;

  localparam int unsigned FRAC      = 16;
  localparam int unsigned SEG_MAX   = 64;
  localparam int unsigned N_CURVES  = 190;
  localparam int unsigned SETTLE    = 40;
  localparam longint unsigned LIMIT = 1500000;

  typedef logic signed [31:0] coord_t;
  typedef coord_t curve_t [8];

  localparam coord_t CMAX = 32'sh7FFFFFFF;
  localparam coord_t CMIN = 32'sh80000000;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [5:0]  k;
    logic        last;
  } curve_point_t;

  class bezier_scoreboard;
    curve_point_t point_q[$];
    int unsigned  seg_count;
    int unsigned  errors;

    function new();
      seg_count = 16;
      errors    = 0;
    endfunction

    function longint lerp(longint a, longint b, longint t);
      return a + (((b - a) * t) >>> FRAC);
    endfunction

    function longint casteljau(longint p0, longint p1, longint p2, longint p3,
                               longint t);
      longint l2, h, l3, r3, r2;
      l2 = lerp(p0, p1, t);
      h  = lerp(p1, p2, t);
      l3 = lerp(l2, h, t);
      r3 = lerp(p2, p3, t);
      r2 = lerp(h, r3, t);
      return lerp(l3, r2, t);
    endfunction

    // expected points for one accepted curve under the current segment count
    function void note_curve(curve_t cp);
      int unsigned  n;
      longint       t, xv, yv;
      curve_point_t p;
      n = (seg_count > SEG_MAX) ? SEG_MAX : seg_count;
      if (n < 2) return;
      for (int unsigned k = 1; k < n; k++) begin
        t      = longint'((k << FRAC) / n);
        xv     = casteljau(cp[0], cp[2], cp[4], cp[6], t);
        yv     = casteljau(cp[1], cp[3], cp[5], cp[7], t);
        p.x    = xv[31:0];
        p.y    = yv[31:0];
        p.k    = k[5:0];
        p.last = (k == n - 1);
        point_q.insert(point_q.size(), p);
      end
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_point(logic [31:0] x, logic [31:0] y, logic [5:0] k,
                              logic last);
      curve_point_t want;
      if (point_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected point, expected none, actual x=%h y=%h k=%0d last=%b",
                 $time, x, y, k, last);
        return;
      end
      want = point_q.pop_front();
      compare("pt_x", want.x, x);
      compare("pt_y", want.y, y);
      compare("step_index", 32'(want.k), 32'(k));
      compare("last_point", 32'(want.last), 32'(last));
    endfunction

    function int unsigned pending();
      return point_q.size();
    endfunction
  endclass

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             cfg_we      = 1'b0;
  logic [SEG_W-1:0] cfg_data    = '0;
  logic             start       = 1'b0;
  logic             busy;
  logic [31:0]      p0_x        = '0;
  logic [31:0]      p0_y        = '0;
  logic [31:0]      p1_x        = '0;
  logic [31:0]      p1_y        = '0;
  logic [31:0]      p2_x        = '0;
  logic [31:0]      p2_y        = '0;
  logic [31:0]      p3_x        = '0;
  logic [31:0]      p3_y        = '0;
  logic             point_valid;
  logic [31:0]      pt_x;
  logic [31:0]      pt_y;
  logic [5:0]       step_index;
  logic             last_point;

  bezier_scoreboard sb = new();
  bit               idle_on = 1'b1;
  longint unsigned  cycles  = 0;

  cubic_bezier_point_generator u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .p0_x        (p0_x),
    .p0_y        (p0_y),
    .p1_x        (p1_x),
    .p1_y        (p1_y),
    .p2_x        (p2_x),
    .p2_y        (p2_y),
    .p3_x        (p3_x),
    .p3_y        (p3_y),
    .point_valid (point_valid),
    .pt_x        (pt_x),
    .pt_y        (pt_y),
    .step_index  (step_index),
    .last_point  (last_point)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && point_valid)
      sb.check_point(pt_x, pt_y, step_index, last_point);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic coord_t rand_coord();
    int unsigned sel;
    coord_t      v;
    sel = $urandom_range(0, 99);
    v   = $urandom;
    if (sel < 55) return v;
    if (sel < 85) return v >>> $urandom_range(8, 20);
    case ($urandom_range(0, 4))
      0:       return CMIN;
      1:       return CMAX;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic curve_t rand_curve();
    curve_t cp;
    for (int i = 0; i < 8; i++) cp[i] = rand_coord();
    return cp;
  endfunction

  // x runs a,b,a,b and y runs b,a,b,a
  function automatic curve_t pattern_curve(coord_t a, coord_t b);
    curve_t cp;
    for (int i = 0; i < 4; i++) begin
      cp[2*i]     = (i % 2 == 0) ? a : b;
      cp[2*i + 1] = (i % 2 == 0) ? b : a;
    end
    return cp;
  endfunction

  // offers the curve each cycle unless idling; taken when start high, busy low
  task automatic send_curve(curve_t cp);
    bit offered, taken;
    taken = 1'b0;
    while (!taken) begin
      if (idle_on && $urandom_range(0, 99) < 19) begin
        start   <= 1'b0;
        offered  = 1'b0;
      end else begin
        start   <= 1'b1;
        p0_x    <= cp[0];
        p0_y    <= cp[1];
        p1_x    <= cp[2];
        p1_y    <= cp[3];
        p2_x    <= cp[4];
        p2_y    <= cp[5];
        p3_x    <= cp[6];
        p3_y    <= cp[7];
        offered  = 1'b1;
      end
      @(posedge clk);
      taken = offered && !busy;
    end
    sb.note_curve(cp);
  endtask

  // segment count changes only once the block has drained
  task automatic set_segments(logic [SEG_W-1:0] value);
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    sb.seg_count = value;
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned sel, seg, reps, curves_done, phase;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset segment count, extreme coordinates
    send_curve(pattern_curve(32'sd0, 32'sd0));
    send_curve(pattern_curve(CMAX, CMAX));
    send_curve(pattern_curve(CMIN, CMIN));
    send_curve(pattern_curve(CMIN, CMAX));
    send_curve(pattern_curve(CMAX, CMIN));
    send_curve(pattern_curve(-32'sd1, 32'sd1));
    send_curve(rand_curve());
    set_segments(7'd2);
    send_curve(pattern_curve(CMIN, CMAX));
    send_curve(rand_curve());
    set_segments(7'd64);
    send_curve(pattern_curve(CMAX, CMIN));
    send_curve(rand_curve());
    // counts above the maximum act as the maximum
    set_segments(7'd127);
    send_curve(pattern_curve(CMIN, CMAX));
    set_segments(7'd65);
    send_curve(rand_curve());
    // counts below two take the curve and emit nothing
    set_segments(7'd0);
    send_curve(pattern_curve(CMIN, CMAX));
    send_curve(rand_curve());
    set_segments(7'd1);
    send_curve(rand_curve());
    set_segments(7'd3);
    send_curve(pattern_curve(CMAX, 32'sd0));
    send_curve(rand_curve());

    curves_done = 0;
    phase       = 0;
    while (curves_done < N_CURVES) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        seg  = $urandom_range(2, 8);
        reps = $urandom_range(4, 12);
      end else if (sel < 75) begin
        seg  = $urandom_range(9, 40);
        reps = $urandom_range(2, 5);
      end else if (sel < 85) begin
        seg  = $urandom_range(41, 64);
        reps = 2;
      end else if (sel < 92) begin
        seg  = $urandom_range(65, 127);
        reps = 2;
      end else begin
        seg  = $urandom_range(0, 1);
        reps = 2;
      end
      set_segments(seg[SEG_W-1:0]);
      // a stretch of back-to-back transactions with no idling
      idle_on = !(phase >= 6 && phase < 10);
      repeat (reps) begin
        send_curve(rand_curve());
        curves_done++;
      end
      phase++;
    end
    start <= 1'b0;

    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
